[rtl/owbm_pkg.sv]
package owbm_pkg;

  // Timer width of the phase counter. Phase lengths above 2**TIMER_BITS saturate.
  localparam int unsigned TIMER_BITS = 10;
  localparam int unsigned REG_W      = 10;
  localparam int unsigned LEN_W      = ((TIMER_BITS > REG_W) ? TIMER_BITS : REG_W) + 1;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RST_LOW  = 3'd0;
  localparam logic [2:0] REG_RST_REL  = 3'd1;
  localparam logic [2:0] REG_SLOT     = 3'd2;
  localparam logic [2:0] REG_WR_HOLD  = 3'd3;
  localparam logic [2:0] REG_RD_REL   = 3'd4;
  localparam logic [2:0] REG_RD_REST  = 3'd5;

  localparam logic [REG_W-1:0] RST_LOW_INIT  = REG_W'(490);
  localparam logic [REG_W-1:0] RST_REL_INIT  = REG_W'(580);
  localparam logic [REG_W-1:0] SLOT_INIT     = REG_W'(2);
  localparam logic [REG_W-1:0] WR_HOLD_INIT  = REG_W'(45);
  localparam logic [REG_W-1:0] RD_REL_INIT   = REG_W'(4);
  localparam logic [REG_W-1:0] RD_REST_INIT  = REG_W'(65);

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_REL  = 3'd2,
    PH_WR_START = 3'd3,
    PH_WR_HOLD  = 3'd4,
    PH_RD_START = 3'd5,
    PH_RD_REL   = 3'd6,
    PH_RD_REST  = 3'd7
  } phase_e;

  // Reflected CRC-8, one byte folded in bit by bit.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Phase length in ticks: zero counts as one, large values saturate.
  function automatic logic [LEN_W-1:0] phase_len(input logic [REG_W-1:0] d);
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cap;
    cap = LEN_W'(1) << TIMER_BITS;
    len = (d == '0) ? LEN_W'(1) : LEN_W'(d);
    if (len > cap) begin
      len = cap;
    end
    return len;
  endfunction

endpackage

[rtl/onewire_bus_master_unit.sv]
// One-wire bus master: an item's result is registered at the edge that accepts it.
// Throughput is one item per cycle while results are taken, limited only by the output
// register, which is refilled at the same edge at which its result is taken.
// Reset (rst_ni low, asynchronous) sets the master idle with the line released,
// clears the counters, shift register, received byte and CRC, and loads the
// default timing registers.
module onewire_bus_master_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic [7:0]                        write_value_i,
  input  logic                              line_level_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              line_release_o,
  output logic                              busy_res_o,
  output logic                              op_done_o,
  output logic [7:0]                        rx_byte_o,
  output logic [7:0]                        crc_value_o,
  output logic                              cmd_rejected_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [owbm_pkg::ADDR_W-1:0]       paddr,
  input  logic [owbm_pkg::DATA_W-1:0]       pwdata,
  output logic [owbm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  // ---------------------------------------------------------------------------
  // Timing registers. Each one is a separate flop group so that the phase
  // length mux and the read-back mux do not share an addressed array.
  // ---------------------------------------------------------------------------
  logic [owbm_pkg::REG_W-1:0] rst_low_q, rst_rel_q, slot_q, wr_hold_q, rd_rel_q, rd_rest_q;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q <= owbm_pkg::RST_LOW_INIT;
      rst_rel_q <= owbm_pkg::RST_REL_INIT;
      slot_q    <= owbm_pkg::SLOT_INIT;
      wr_hold_q <= owbm_pkg::WR_HOLD_INIT;
      rd_rel_q  <= owbm_pkg::RD_REL_INIT;
      rd_rest_q <= owbm_pkg::RD_REST_INIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        owbm_pkg::REG_RST_LOW: rst_low_q <= pwdata[owbm_pkg::REG_W-1:0];
        owbm_pkg::REG_RST_REL: rst_rel_q <= pwdata[owbm_pkg::REG_W-1:0];
        owbm_pkg::REG_SLOT:    slot_q    <= pwdata[owbm_pkg::REG_W-1:0];
        owbm_pkg::REG_WR_HOLD: wr_hold_q <= pwdata[owbm_pkg::REG_W-1:0];
        owbm_pkg::REG_RD_REL:  rd_rel_q  <= pwdata[owbm_pkg::REG_W-1:0];
        owbm_pkg::REG_RD_REST: rd_rest_q <= pwdata[owbm_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back is combinational; addresses past the register list read as zero.
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      owbm_pkg::REG_RST_LOW: prdata = owbm_pkg::DATA_W'(rst_low_q);
      owbm_pkg::REG_RST_REL: prdata = owbm_pkg::DATA_W'(rst_rel_q);
      owbm_pkg::REG_SLOT:    prdata = owbm_pkg::DATA_W'(slot_q);
      owbm_pkg::REG_WR_HOLD: prdata = owbm_pkg::DATA_W'(wr_hold_q);
      owbm_pkg::REG_RD_REL:  prdata = owbm_pkg::DATA_W'(rd_rel_q);
      owbm_pkg::REG_RD_REST: prdata = owbm_pkg::DATA_W'(rd_rest_q);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The bus state registers double as the result payload: they only
  // change when an item is accepted, and an item is only accepted when the
  // pending result leaves at the same edge (or there is none).
  // ---------------------------------------------------------------------------
  logic accept;
  logic out_valid_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------------
  // Sequencer state.
  // ---------------------------------------------------------------------------
  owbm_pkg::phase_e                    phase_q, phase_d;
  logic [owbm_pkg::TIMER_BITS-1:0]     tick_q, tick_d;
  logic [2:0]                          bit_q, bit_d;
  logic [7:0]                          shift_q, shift_d;
  logic [7:0]                          rx_q, rx_d;
  logic [7:0]                          crc_q, crc_d;
  logic                                line_q, line_d;
  logic                                done_q, done_d;
  logic                                rej_q, rej_d;

  owbm_pkg::cmd_e                      cmd;
  logic                                busy;
  logic                                start;
  logic                                step;
  logic                                phase_end;
  logic                                last_bit;
  logic [owbm_pkg::REG_W-1:0]          len_reg;
  logic [owbm_pkg::LEN_W-1:0]          len;
  logic [owbm_pkg::LEN_W-1:0]          tick_inc;

  assign cmd      = owbm_pkg::cmd_e'(cmd_i);
  assign busy     = (phase_q != owbm_pkg::PH_IDLE);
  // A command only starts an operation from idle; a tick only advances a busy one.
  assign start    = accept & (cmd != owbm_pkg::CMD_TICK) & ~busy;
  assign step     = accept & (cmd == owbm_pkg::CMD_TICK) & busy;
  assign last_bit = (bit_q == owbm_pkg::LAST_BIT);

  // Select the length register of the current phase. Both slot openers share one.
  always_comb begin
    len_reg = owbm_pkg::RD_REST_INIT;
    unique case (phase_q)
      owbm_pkg::PH_RST_LOW:  len_reg = rst_low_q;
      owbm_pkg::PH_RST_REL:  len_reg = rst_rel_q;
      owbm_pkg::PH_WR_START: len_reg = slot_q;
      owbm_pkg::PH_WR_HOLD:  len_reg = wr_hold_q;
      owbm_pkg::PH_RD_START: len_reg = slot_q;
      owbm_pkg::PH_RD_REL:   len_reg = rd_rel_q;
      owbm_pkg::PH_RD_REST:  len_reg = rd_rest_q;
      default:               len_reg = rd_rest_q;
    endcase
  end

  assign len       = owbm_pkg::phase_len(len_reg);
  assign tick_inc  = owbm_pkg::LEN_W'(tick_q) + owbm_pkg::LEN_W'(1);
  // The phase ends on the tick that brings the count up to its length.
  assign phase_end = ~(tick_inc < len);

  // Next-state logic: phase and phase timer.
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    if (start) begin
      tick_d = '0;
      unique case (cmd)
        owbm_pkg::CMD_RESET: phase_d = owbm_pkg::PH_RST_LOW;
        owbm_pkg::CMD_WRITE: phase_d = owbm_pkg::PH_WR_START;
        owbm_pkg::CMD_READ:  phase_d = owbm_pkg::PH_RD_START;
        default:             phase_d = phase_q;
      endcase
    end else if (step) begin
      if (!phase_end) begin
        tick_d = tick_inc[owbm_pkg::TIMER_BITS-1:0];
      end else begin
        tick_d = '0;
        unique case (phase_q)
          owbm_pkg::PH_RST_LOW:  phase_d = owbm_pkg::PH_RST_REL;
          owbm_pkg::PH_RST_REL:  phase_d = owbm_pkg::PH_IDLE;
          owbm_pkg::PH_WR_START: phase_d = owbm_pkg::PH_WR_HOLD;
          owbm_pkg::PH_WR_HOLD:  phase_d = last_bit ? owbm_pkg::PH_IDLE : owbm_pkg::PH_WR_START;
          owbm_pkg::PH_RD_START: phase_d = owbm_pkg::PH_RD_REL;
          owbm_pkg::PH_RD_REL:   phase_d = owbm_pkg::PH_RD_REST;
          owbm_pkg::PH_RD_REST:  phase_d = last_bit ? owbm_pkg::PH_IDLE : owbm_pkg::PH_RD_START;
          default:               phase_d = owbm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Output and datapath logic: line level, shift register, bit counter, CRC.
  always_comb begin
    line_d  = line_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    rx_d    = rx_q;
    crc_d   = crc_q;
    done_d  = 1'b0;
    rej_d   = accept & (cmd != owbm_pkg::CMD_TICK) & busy;
    if (start) begin
      // Every operation opens by pulling the line low right away.
      line_d = 1'b0;
      bit_d  = '0;
      unique case (cmd)
        owbm_pkg::CMD_RESET: crc_d   = '0;
        owbm_pkg::CMD_WRITE: shift_d = write_value_i;
        owbm_pkg::CMD_READ:  shift_d = '0;
        default:             shift_d = shift_q;
      endcase
    end else if (step && phase_end) begin
      unique case (phase_q)
        owbm_pkg::PH_RST_LOW: line_d = 1'b1;
        owbm_pkg::PH_RST_REL: begin
          line_d = 1'b1;
          done_d = 1'b1;
        end
        owbm_pkg::PH_WR_START: line_d = shift_q[0];
        owbm_pkg::PH_WR_HOLD: begin
          shift_d = shift_q >> 1;
          if (last_bit) begin
            bit_d  = '0;
            line_d = 1'b1;
            done_d = 1'b1;
          end else begin
            // The release between write slots is untimed: the next low pulse starts now.
            bit_d  = bit_q + 3'd1;
            line_d = 1'b0;
          end
        end
        owbm_pkg::PH_RD_START: line_d = 1'b1;
        owbm_pkg::PH_RD_REL: begin
          shift_d = {line_level_i, shift_q[7:1]};
          line_d  = 1'b1;
        end
        owbm_pkg::PH_RD_REST: begin
          if (last_bit) begin
            bit_d  = '0;
            rx_d   = shift_q;
            crc_d  = owbm_pkg::crc8_byte(crc_q, shift_q);
            line_d = 1'b1;
            done_d = 1'b1;
          end else begin
            bit_d  = bit_q + 3'd1;
            line_d = 1'b0;
          end
        end
        default: line_d = line_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      rx_q        <= '0;
      crc_q       <= '0;
      line_q      <= 1'b1;
      done_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        rx_q    <= rx_d;
        crc_q   <= crc_d;
        line_q  <= line_d;
        done_q  <= done_d;
        rej_q   <= rej_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_release_o = line_q;
  assign busy_res_o     = busy;
  assign op_done_o      = done_q;
  assign rx_byte_o      = rx_q;
  assign crc_value_o    = crc_q;
  assign cmd_rejected_o = rej_q;

endmodule

[rtl/owbm_checker.sv]
module owbm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        line_release_o,
  input logic                        busy_res_o,
  input logic                        op_done_o,
  input logic                        cmd_rejected_o
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted item yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // Finishing an operation leaves the master idle with the line released.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_done_o |-> !busy_res_o && line_release_o)
    else $error("operation done but master still busy or line low");

  // A rejected command can only happen while busy and never on a finishing tick.
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmd_rejected_o |-> busy_res_o && !op_done_o)
    else $error("command rejected while idle or on a done tick");

endmodule

bind onewire_bus_master_unit owbm_checker u_owbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .line_release_o (line_release_o),
  .busy_res_o     (busy_res_o),
  .op_done_o      (op_done_o),
  .cmd_rejected_o (cmd_rejected_o)
);

[tb/onewire_bus_master_unit_tb.sv]
`timescale 1ns / 100ps

module onewire_bus_master_unit_tb;
  import owbm_pkg::*;

  // One result per item, in the order of the output fields.
  typedef struct packed {
    logic       line_release;
    logic       busy;
    logic       done;
    logic [7:0] rd_byte;
    logic [7:0] crc;
    logic       rejected;
  } bus_result_t;

  // Clock, reset and every block input start from a known value.
  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic [1:0]          cmd_i         = CMD_TICK;
  logic [7:0]          write_value_i = 8'h00;
  logic                line_level_i  = 1'b0;
  logic                out_ready_i   = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;

  logic                in_ready_o;
  logic                out_valid_o;
  logic                line_release_o;
  logic                busy_res_o;
  logic                op_done_o;
  logic [7:0]          rx_byte_o;
  logic [7:0]          crc_value_o;
  logic                cmd_rejected_o;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Shadow of the master: timing registers and bus sequencer state, kept in step
  // with the items that the block has accepted.
  logic [REG_W-1:0] timing [NUM_REGS] = '{RST_LOW_INIT, RST_REL_INIT, SLOT_INIT,
                                          WR_HOLD_INIT, RD_REL_INIT, RD_REST_INIT};
  phase_e           ph       = PH_IDLE;
  int unsigned      tick_cnt = 0;
  logic [2:0]       bit_pos  = 3'd0;
  logic [7:0]       shreg    = 8'h00;
  logic [7:0]       rx_byte  = 8'h00;
  logic [7:0]       crc_acc  = 8'h00;
  logic             line_lvl = 1'b1;

  // Results predicted for accepted items, oldest first.
  bus_result_t pending_results [$];
  int unsigned errors       = 0;
  // Ticks while busy and commands while idle; these move the master forward.
  int unsigned useful_items = 0;
  // When clear, neither side inserts idle cycles.
  bit          gaps_on      = 1'b1;

  onewire_bus_master_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .write_value_i  (write_value_i),
    .line_level_i   (line_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_release_o (line_release_o),
    .busy_res_o     (busy_res_o),
    .op_done_o      (op_done_o),
    .rx_byte_o      (rx_byte_o),
    .crc_value_o    (crc_value_o),
    .cmd_rejected_o (cmd_rejected_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A register value of zero still lasts one tick. The registers are only ten
  // bits wide, so the saturation at 2**TIMER_BITS can never be reached here.
  function automatic int unsigned ticks_of(logic [REG_W-1:0] r);
    return (r == '0) ? 1 : int'(r);
  endfunction

  // Reflected CRC-8 processed one data bit at a time, LSB first.
  function automatic logic [7:0] crc_fold(logic [7:0] c, logic [7:0] d);
    logic [7:0] r;
    logic       mix;
    r = c;
    for (int i = 0; i < 8; i++) begin
      mix = r[0] ^ d[i];
      r = r >> 1;
      if (mix) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void enter_phase(phase_e p, logic l);
    ph       = p;
    tick_cnt = 0;
    line_lvl = l;
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic bus_result_t advance_master(cmd_e c, logic [7:0] wv, logic lvl);
    bus_result_t r;
    int unsigned len;
    r = '0;
    len = 1;
    if (c != CMD_TICK) begin
      // A command never consumes a tick; while busy it is dropped and flagged.
      if (ph != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        case (c)
          CMD_RESET: begin
            crc_acc = 8'h00;
            enter_phase(PH_RST_LOW, 1'b0);
          end
          CMD_WRITE: begin
            shreg   = wv;
            bit_pos = 3'd0;
            enter_phase(PH_WR_START, 1'b0);
          end
          default: begin
            shreg   = 8'h00;
            bit_pos = 3'd0;
            enter_phase(PH_RD_START, 1'b0);
          end
        endcase
      end
    end else if (ph != PH_IDLE) begin
      case (ph)
        PH_RST_LOW:  len = ticks_of(timing[REG_RST_LOW]);
        PH_RST_REL:  len = ticks_of(timing[REG_RST_REL]);
        PH_WR_START: len = ticks_of(timing[REG_SLOT]);
        PH_WR_HOLD:  len = ticks_of(timing[REG_WR_HOLD]);
        PH_RD_START: len = ticks_of(timing[REG_SLOT]);
        PH_RD_REL:   len = ticks_of(timing[REG_RD_REL]);
        default:     len = ticks_of(timing[REG_RD_REST]);
      endcase
      if (tick_cnt + 1 < len) begin
        tick_cnt++;
      end else begin
        case (ph)
          PH_RST_LOW: begin
            enter_phase(PH_RST_REL, 1'b1);
          end
          PH_RST_REL: begin
            enter_phase(PH_IDLE, 1'b1);
            r.done = 1'b1;
          end
          PH_WR_START: begin
            enter_phase(PH_WR_HOLD, shreg[0]);
          end
          PH_WR_HOLD: begin
            // The release between write slots is untimed: the next slot opens now.
            shreg = shreg >> 1;
            if (bit_pos == LAST_BIT) begin
              bit_pos = 3'd0;
              enter_phase(PH_IDLE, 1'b1);
              r.done = 1'b1;
            end else begin
              bit_pos++;
              enter_phase(PH_WR_START, 1'b0);
            end
          end
          PH_RD_START: begin
            enter_phase(PH_RD_REL, 1'b1);
          end
          PH_RD_REL: begin
            // The bus is sampled on the tick that closes the release wait.
            shreg = {lvl, shreg[7:1]};
            enter_phase(PH_RD_REST, 1'b1);
          end
          default: begin
            if (bit_pos == LAST_BIT) begin
              bit_pos = 3'd0;
              rx_byte = shreg;
              crc_acc = crc_fold(crc_acc, shreg);
              enter_phase(PH_IDLE, 1'b1);
              r.done = 1'b1;
            end else begin
              bit_pos++;
              enter_phase(PH_RD_START, 1'b0);
            end
          end
        endcase
      end
    end
    r.line_release = line_lvl;
    r.busy         = (ph != PH_IDLE);
    r.rd_byte      = rx_byte;
    r.crc          = crc_acc;
    return r;
  endfunction

  // Presents one item, holds it until the block takes it, then predicts its result.
  // Valid is left high; the next call either replaces the payload or lowers it.
  task automatic send_item(cmd_e c, logic [7:0] wv, logic lvl);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    write_value_i <= wv;
    line_level_i  <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if ((c == CMD_TICK) == (ph != PH_IDLE)) begin
      useful_items++;
    end
    pending_results.push_back(advance_master(c, wv, lvl));
  endtask

  // Ticks with random bus levels until the running operation has completed.
  task automatic finish_op();
    while (ph != PH_IDLE) begin
      send_item(CMD_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // Issues a command and then ticks it to completion. During a read the bus level
  // on every tick follows the bit of the pattern for the current slot, so the
  // received byte equals the pattern. A small share of the items are stray
  // commands that arrive while the master is busy.
  task automatic run_op(cmd_e c, logic [7:0] wv, logic [7:0] pattern,
                        int unsigned noise_pct);
    send_item(c, wv, 1'($urandom));
    while (ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(cmd_e'(2'($urandom_range(1, 3))), 8'($urandom), 1'($urandom));
      end else begin
        send_item(CMD_TICK, 8'($urandom), pattern[bit_pos]);
      end
    end
  endtask

  // Stops sending and waits until every predicted result has been taken. Every
  // item produces exactly one result, so an empty store means nothing is left
  // in flight.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Brings the bus sequencer to idle, drains the result channel and then rewrites
  // all six timing registers through the configuration port.
  task automatic apply_timing(input int unsigned t0, t1, t2, t3, t4, t5);
    logic [REG_W-1:0] vals [NUM_REGS];
    vals = '{REG_W'(t0), REG_W'(t1), REG_W'(t2), REG_W'(t3), REG_W'(t4), REG_W'(t5)};
    finish_op();
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {3'(i), 2'b00};
      pwdata  <= DATA_W'(vals[i]);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      timing[i] = vals[i];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // Timing after reset: idle ticks, then one write at the default slot and hold
  // times, with stray commands rejected while it runs.
  task automatic test_default_timing();
    send_item(CMD_TICK, 8'h00, 1'b0);
    send_item(CMD_TICK, 8'hFF, 1'b1);
    send_item(CMD_WRITE, 8'hA5, 1'b1);
    send_item(CMD_READ, 8'h00, 1'b0);
    send_item(CMD_RESET, 8'h00, 1'b1);
    send_item(CMD_WRITE, 8'h3C, 1'b0);
    finish_op();
  endtask

  // All registers zero: every phase lasts a single tick. Covers extreme write
  // values, reads of all ones and all zeros, and the CRC clear by a reset pulse.
  task automatic test_zero_timing();
    apply_timing(0, 0, 0, 0, 0, 0);
    run_op(CMD_WRITE, 8'h00, 8'h00, 0);
    run_op(CMD_WRITE, 8'hFF, 8'h00, 0);
    run_op(CMD_READ, 8'h00, 8'hFF, 0);
    run_op(CMD_READ, 8'h00, 8'h00, 0);
    run_op(CMD_RESET, 8'h00, 8'h00, 0);
    run_op(CMD_READ, 8'h00, 8'h81, 0);
    send_item(CMD_TICK, 8'h55, 1'b1);
  endtask

  // Longer phases that take the counter well past the short settings. These
  // runs are long, so both sides go without gaps.
  task automatic test_long_timing();
    gaps_on = 1'b0;
    apply_timing(150, 60, 1, 1, 1, 1);
    run_op(CMD_RESET, 8'h00, 8'h00, 0);
    gaps_on = 1'b1;
  endtask

  // Mostly complete operations with random data and bus levels, mixed with stray
  // items and the occasional full drain, over several short timing settings.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned roll;
    for (int round = 0; round < 4; round++) begin
      if (round == 0) begin
        apply_timing(1, 1, 1, 1, 1, 1);
      end else begin
        apply_timing($urandom_range(0, 1 + round), $urandom_range(1, 1 + round),
                     $urandom_range(1, 1 + round), $urandom_range(1, 1 + round),
                     $urandom_range(1, 1 + round), $urandom_range(0, 1 + round));
      end
      target = useful_items + 25;
      while (useful_items < target) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          run_op(cmd_e'(2'($urandom_range(1, 3))), 8'($urandom), 8'($urandom), 5);
        end else if (roll < 95) begin
          send_item(cmd_e'(2'($urandom)), 8'($urandom), 1'($urandom));
        end else begin
          drain_results();
        end
      end
    end
    gaps_on = 1'b1;
    finish_op();
  endtask

  // Result side: draws a stall before each result, or none while gaps are off.
  // Ready is raised and then held until a result has been taken.
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = gaps_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Every result taken is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("line_release", 8'(want.line_release), 8'(line_release_o));
        check_field("busy_res", 8'(want.busy), 8'(busy_res_o));
        check_field("op_done", 8'(want.done), 8'(op_done_o));
        check_field("rx_byte", want.rd_byte, rx_byte_o);
        check_field("crc_value", want.crc, crc_value_o);
        check_field("cmd_rejected", 8'(want.rejected), 8'(cmd_rejected_o));
      end
    end
  end

  // Main sequence: reset once, run the tests in turn, drain, report.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timing();
    test_zero_timing();
    test_long_timing();
    test_random_traffic();
    drain_results();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
